// ===== src/crc_pkg.sv =====
// ----------------------------------------------------------------------------
// crc_pkg
// Shared types, codes and the constant binomial table for the rank codec.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package crc_pkg;

  localparam int POS_W     = 5;
  localparam int ID_W      = 24;
  localparam int BIN_W     = 16;
  localparam int MAX_N     = 32;
  localparam int MAX_K     = 4;
  localparam int BLK_SLOTS = 3;
  localparam int MRK_SLOTS = 4;

  localparam logic KIND_ENCODE = 1'b0;
  localparam logic KIND_DECODE = 1'b1;

  typedef logic [POS_W-1:0]       pos_t;
  typedef pos_t [BLK_SLOTS-1:0]   blk_set_t;
  typedef pos_t [MRK_SLOTS-1:0]   mrk_set_t;
  typedef logic [BIN_W-1:0]       binom_t;
  typedef binom_t [MAX_K:0]       binom_row_t;
  typedef binom_row_t [MAX_N:0]   binom_tab_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  // sorted sets, compressed marks and input check from the front end
  typedef struct packed {
    blk_set_t blk;
    mrk_set_t mrk;
    mrk_set_t cmp;
    logic     bad;
  } sort_res_t;

  // pascal triangle, additions only
  function automatic binom_tab_t binom_table();
    binom_tab_t t;
    t = '0;
    for (int n = 0; n <= MAX_N; n++) begin
      t[n][0] = binom_t'(1);
      for (int k = 1; k <= MAX_K; k++) begin
        if (n > 0) begin
          t[n][k] = t[n-1][k-1] + t[n-1][k];
        end
      end
    end
    return t;
  endfunction

  localparam binom_tab_t BINOM = binom_table();

endpackage

// ===== src/crc_in_if.sv =====
// ----------------------------------------------------------------------------
// crc_in_if
// Request channel of the rank codec: operation kind, positions and id.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface crc_in_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [crc_pkg::POS_W-1:0]  black_in_a;
  logic [crc_pkg::POS_W-1:0]  black_in_b;
  logic [crc_pkg::POS_W-1:0]  black_in_c;
  logic [crc_pkg::POS_W-1:0]  mark_in_a;
  logic [crc_pkg::POS_W-1:0]  mark_in_b;
  logic [crc_pkg::POS_W-1:0]  mark_in_c;
  logic [crc_pkg::POS_W-1:0]  mark_in_d;
  logic [crc_pkg::ID_W-1:0]   id_in;

  modport source (
    output valid, kind, black_in_a, black_in_b, black_in_c,
           mark_in_a, mark_in_b, mark_in_c, mark_in_d, id_in,
    input  ready
  );

  modport sink (
    input  valid, kind, black_in_a, black_in_b, black_in_c,
           mark_in_a, mark_in_b, mark_in_c, mark_in_d, id_in,
    output ready
  );
endinterface

// ===== src/crc_out_if.sv =====
// ----------------------------------------------------------------------------
// crc_out_if
// Result channel of the rank codec: id, sorted positions and input flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface crc_out_if;
  logic                       valid;
  logic                       ready;
  logic [crc_pkg::ID_W-1:0]   id_out;
  logic [crc_pkg::POS_W-1:0]  black_out_a;
  logic [crc_pkg::POS_W-1:0]  black_out_b;
  logic [crc_pkg::POS_W-1:0]  black_out_c;
  logic [crc_pkg::POS_W-1:0]  mark_out_a;
  logic [crc_pkg::POS_W-1:0]  mark_out_b;
  logic [crc_pkg::POS_W-1:0]  mark_out_c;
  logic [crc_pkg::POS_W-1:0]  mark_out_d;
  logic                       bad_input;

  modport source (
    output valid, id_out, black_out_a, black_out_b, black_out_c,
           mark_out_a, mark_out_b, mark_out_c, mark_out_d, bad_input,
    input  ready
  );

  modport sink (
    input  valid, id_out, black_out_a, black_out_b, black_out_c,
           mark_out_a, mark_out_b, mark_out_c, mark_out_d, bad_input,
    output ready
  );
endinterface

// ===== src/crc_alu.sv =====
// ----------------------------------------------------------------------------
// crc_alu
// Shared add / subtract unit with an unsigned greater-or-equal flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crc_alu #(
  parameter int W = 24
) (
  input  logic [W-1:0]     a,
  input  logic [W-1:0]     b,
  input  crc_pkg::alu_op_t op,
  output logic [W-1:0]     y,
  output logic             ge
);

  logic [W:0] diff;

  assign diff = {1'b0, a} - {1'b0, b};
  assign ge   = ~diff[W];

  always_comb begin
    case (op)
      crc_pkg::ALU_ADD: y = a + b;
      crc_pkg::ALU_SUB: y = diff[W-1:0];
      default:          y = diff[W-1:0];
    endcase
  end

endmodule

// ===== src/crc_sort.sv =====
// ----------------------------------------------------------------------------
// crc_sort
// Encode front end: sorts both sets, checks range and repeats, and renumbers
// the tracked positions over the points left free by black.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crc_sort #(
  parameter int POINTS = 23,
  parameter int UB     = 3,
  parameter int MC     = 4
) (
  input  crc_pkg::blk_set_t  blk_raw,
  input  crc_pkg::mrk_set_t  mrk_raw,
  output crc_pkg::sort_res_t res
);

  localparam int ALL_N = UB + MC;

  logic [1:0]        brank [crc_pkg::BLK_SLOTS];
  logic [1:0]        mrank [crc_pkg::MRK_SLOTS];
  logic [1:0]        below [crc_pkg::MRK_SLOTS];
  crc_pkg::pos_t     all_pos [ALL_N];
  crc_pkg::blk_set_t blk_s;
  crc_pkg::mrk_set_t mrk_s;
  crc_pkg::mrk_set_t cmp_s;
  logic              bad_s;

  // rank of each element, ties broken by slot so ranks stay distinct
  always_comb begin
    for (int i = 0; i < crc_pkg::BLK_SLOTS; i++) begin
      brank[i] = 2'd0;
    end
    for (int i = 0; i < crc_pkg::MRK_SLOTS; i++) begin
      mrank[i] = 2'd0;
    end
    for (int i = 0; i < UB; i++) begin
      for (int j = 0; j < UB; j++) begin
        if (j != i) begin
          if (blk_raw[j] < blk_raw[i] || (blk_raw[j] == blk_raw[i] && j < i)) begin
            brank[i] = brank[i] + 2'd1;
          end
        end
      end
    end
    for (int i = 0; i < MC; i++) begin
      for (int j = 0; j < MC; j++) begin
        if (j != i) begin
          if (mrk_raw[j] < mrk_raw[i] || (mrk_raw[j] == mrk_raw[i] && j < i)) begin
            mrank[i] = mrank[i] + 2'd1;
          end
        end
      end
    end
  end

  always_comb begin
    blk_s = '0;
    mrk_s = '0;
    for (int k = 0; k < UB; k++) begin
      for (int i = 0; i < UB; i++) begin
        if (brank[i] == 2'(k)) begin
          blk_s[k] = blk_raw[i];
        end
      end
    end
    for (int k = 0; k < MC; k++) begin
      for (int i = 0; i < MC; i++) begin
        if (mrank[i] == 2'(k)) begin
          mrk_s[k] = mrk_raw[i];
        end
      end
    end
  end

  // tracked position minus the black points below it
  always_comb begin
    cmp_s = '0;
    for (int i = 0; i < crc_pkg::MRK_SLOTS; i++) begin
      below[i] = 2'd0;
    end
    for (int i = 0; i < MC; i++) begin
      for (int j = 0; j < UB; j++) begin
        if (blk_raw[j] < mrk_s[i]) begin
          below[i] = below[i] + 2'd1;
        end
      end
      cmp_s[i] = mrk_s[i] - crc_pkg::pos_t'(below[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < UB; i++) begin
      all_pos[i] = blk_raw[i];
    end
    for (int i = 0; i < MC; i++) begin
      all_pos[UB+i] = mrk_raw[i];
    end
    bad_s = 1'b0;
    for (int i = 0; i < ALL_N; i++) begin
      if ({1'b0, all_pos[i]} >= 6'(POINTS)) begin
        bad_s = 1'b1;
      end
      for (int j = i + 1; j < ALL_N; j++) begin
        if (all_pos[i] == all_pos[j]) begin
          bad_s = 1'b1;
        end
      end
    end
  end

  assign res.blk = blk_s;
  assign res.mrk = mrk_s;
  assign res.cmp = cmp_s;
  assign res.bad = bad_s;

endmodule

// ===== src/combination_rank_codec.sv =====
// ----------------------------------------------------------------------------
// combination_rank_codec
// Encode: sorts and checks the sets, then adds one rank term a cycle through the
//   shared adder, then one multiply and one add.
// Decode: checks the id against the total, a bad id going straight to the result;
//   otherwise a reciprocal split, then a binomial search of one candidate a cycle.
// One item at a time; the next is taken once the result sits in the output register.
// Synchronous reset returns the sequencer to idle and drops the result valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module combination_rank_codec #(
  parameter int POINTS      = 23,
  parameter int BLACK_COUNT = 3,
  parameter int MARK_COUNT  = 4
) (
  input logic       clk,
  input logic       rst,
  crc_in_if.sink    req,
  crc_out_if.source rsp
);

  localparam int UB = (BLACK_COUNT > crc_pkg::BLK_SLOTS) ? crc_pkg::BLK_SLOTS : BLACK_COUNT;
  localparam int MC = MARK_COUNT;
  localparam int BSPAN    = int'(crc_pkg::BINOM[POINTS][UB]);
  localparam int MARKSPAN = int'(crc_pkg::BINOM[POINTS-UB][MC]);
  localparam int TOTAL    = BSPAN * MARKSPAN;
  localparam int TOTAL_W  = $clog2(TOTAL + 1);
  localparam int CALC_W   = (TOTAL_W > crc_pkg::ID_W) ? TOTAL_W : crc_pkg::ID_W;
  localparam int QB       = $clog2(BSPAN);
  // quotient by the mark span as a multiply by a rounded-up reciprocal
  localparam int DIV_N    = TOTAL_W;
  localparam int SPAN_W   = $clog2(MARKSPAN);
  localparam int SH       = DIV_N + SPAN_W;
  localparam int RECIP_W  = DIV_N + 1;
  localparam int MUL_W    = DIV_N + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SH) + 64'(MARKSPAN) - 64'd1) / 64'(MARKSPAN));

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_SORT = 12'b0000_0000_0010,
    S_ERB  = 12'b0000_0000_0100,
    S_ERC  = 12'b0000_0000_1000,
    S_EMUL = 12'b0000_0001_0000,
    S_EADD = 12'b0000_0010_0000,
    S_DCHK = 12'b0000_0100_0000,
    S_DDIV = 12'b0000_1000_0000,
    S_DUNM = 12'b0001_0000_0000,
    S_DUNB = 12'b0010_0000_0000,
    S_DEXP = 12'b0100_0000_0000,
    S_FIN  = 12'b1000_0000_0000
  } state_t;

  state_t                   state;
  logic                     kind;
  logic                     bad;
  logic [CALC_W-1:0]        rem;
  logic [CALC_W-1:0]        prod;
  logic [QB-1:0]            quo;
  crc_pkg::pos_t            x;
  logic [2:0]               dig;
  crc_pkg::blk_set_t        blk;
  crc_pkg::mrk_set_t        mrk;
  crc_pkg::mrk_set_t        cmp;

  logic                     out_valid;
  logic [crc_pkg::ID_W-1:0] out_id;
  crc_pkg::blk_set_t        out_blk;
  crc_pkg::mrk_set_t        out_mrk;
  logic                     out_bad;

  crc_pkg::sort_res_t       sres;
  crc_pkg::pos_t            tab_n;
  logic [2:0]               tab_k;
  crc_pkg::binom_t          tab_val;
  logic [CALC_W-1:0]        alu_b;
  crc_pkg::alu_op_t         alu_op;
  logic [CALC_W-1:0]        alu_y;
  logic                     alu_ge;
  crc_pkg::mrk_set_t        placed;
  crc_pkg::blk_set_t        blk_load;
  crc_pkg::mrk_set_t        mrk_load;
  logic [MUL_W-1:0]         recip_prod;
  logic                     fin_go;

  crc_sort #(
    .POINTS (POINTS),
    .UB     (UB),
    .MC     (MC)
  ) u_sort (
    .blk_raw (blk),
    .mrk_raw (mrk),
    .res     (sres)
  );

  crc_alu #(
    .W (CALC_W)
  ) u_alu (
    .a  (rem),
    .b  (alu_b),
    .op (alu_op),
    .y  (alu_y),
    .ge (alu_ge)
  );

  // single read port on the binomial table
  always_comb begin
    tab_n = x;
    tab_k = dig;
    unique case (state)
      S_ERB: begin
        tab_n = blk[dig[1:0]];
        tab_k = dig + 3'd1;
      end
      S_ERC: begin
        tab_n = cmp[dig[1:0]];
        tab_k = dig + 3'd1;
      end
      default: ;
    endcase
  end

  assign tab_val = crc_pkg::BINOM[{1'b0, tab_n}][tab_k];

  always_comb begin
    alu_b  = CALC_W'(tab_val);
    alu_op = crc_pkg::ALU_SUB;
    unique case (state)
      S_ERB, S_ERC: alu_op = crc_pkg::ALU_ADD;
      // encode adds the black term, decode takes the remainder
      S_EADD: begin
        alu_b  = prod;
        alu_op = (kind == crc_pkg::KIND_ENCODE) ? crc_pkg::ALU_ADD : crc_pkg::ALU_SUB;
      end
      S_DCHK:  alu_b = CALC_W'(TOTAL);
      default: ;
    endcase
  end

  assign recip_prod = MUL_W'(rem[DIV_N-1:0]) * MUL_W'(RECIP);

  // raw sets of an accepted item, zero on decode
  always_comb begin
    blk_load = '0;
    mrk_load = '0;
    if (req.kind == crc_pkg::KIND_ENCODE) begin
      blk_load[0] = req.black_in_a;
      if (UB > 1) begin
        blk_load[1] = req.black_in_b;
      end
      if (UB > 2) begin
        blk_load[2] = req.black_in_c;
      end
      mrk_load[0] = req.mark_in_a;
      if (MC > 1) begin
        mrk_load[1] = req.mark_in_b;
      end
      if (MC > 2) begin
        mrk_load[2] = req.mark_in_c;
      end
      if (MC > 3) begin
        mrk_load[3] = req.mark_in_d;
      end
    end
  end

  // map free-point index back to a board position, blacks in ascending order
  always_comb begin
    for (int i = 0; i < crc_pkg::MRK_SLOTS; i++) begin
      placed[i] = cmp[i];
      for (int j = 0; j < UB; j++) begin
        if (blk[j] <= placed[i]) begin
          placed[i] = placed[i] + crc_pkg::pos_t'(1);
        end
      end
    end
  end

  assign fin_go = (state == S_FIN) && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (fin_go) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            kind <= req.kind;
            bad  <= 1'b0;
            rem  <= CALC_W'(req.id_in);
            dig  <= 3'd0;
            blk  <= blk_load;
            mrk  <= mrk_load;
            cmp  <= '0;
            if (req.kind == crc_pkg::KIND_ENCODE) begin
              state <= S_SORT;
            end else begin
              state <= S_DCHK;
            end
          end
        end
        S_SORT: begin
          blk <= sres.blk;
          mrk <= sres.mrk;
          cmp <= sres.cmp;
          bad <= sres.bad;
          rem <= '0;
          dig <= 3'd0;
          state <= sres.bad ? S_FIN : S_ERB;
        end
        S_ERB: begin
          if (dig == 3'(UB - 1)) begin
            quo   <= QB'(alu_y);
            rem   <= '0;
            dig   <= 3'd0;
            state <= S_ERC;
          end else begin
            rem <= alu_y;
            dig <= dig + 3'd1;
          end
        end
        S_ERC: begin
          rem <= alu_y;
          if (dig == 3'(MC - 1)) begin
            state <= S_EMUL;
          end else begin
            dig <= dig + 3'd1;
          end
        end
        S_EMUL: begin
          prod  <= CALC_W'(quo) * CALC_W'(MARKSPAN);
          state <= S_EADD;
        end
        S_EADD: begin
          rem <= alu_y;
          if (kind == crc_pkg::KIND_ENCODE) begin
            state <= S_FIN;
          end else begin
            x     <= crc_pkg::pos_t'(POINTS - UB - 1);
            dig   <= 3'(MC);
            state <= S_DUNM;
          end
        end
        S_DCHK: begin
          if (alu_ge) begin
            bad   <= 1'b1;
            state <= S_FIN;
          end else begin
            state <= S_DDIV;
          end
        end
        S_DDIV: begin
          quo   <= QB'(recip_prod >> SH);
          state <= S_EMUL;
        end
        S_DUNM: begin
          if (x != '0 && !alu_ge) begin
            x <= x - crc_pkg::pos_t'(1);
          end else begin
            cmp[2'(dig - 3'd1)] <= x;
            if (dig == 3'd1) begin
              rem   <= CALC_W'(quo);
              x     <= crc_pkg::pos_t'(POINTS - 1);
              dig   <= 3'(UB);
              state <= S_DUNB;
            end else begin
              rem <= alu_y;
              x   <= x - crc_pkg::pos_t'(1);
              dig <= dig - 3'd1;
            end
          end
        end
        S_DUNB: begin
          if (x != '0 && !alu_ge) begin
            x <= x - crc_pkg::pos_t'(1);
          end else begin
            blk[2'(dig - 3'd1)] <= x;
            rem <= alu_y;
            if (dig == 3'd1) begin
              state <= S_DEXP;
            end else begin
              x   <= x - crc_pkg::pos_t'(1);
              dig <= dig - 3'd1;
            end
          end
        end
        S_DEXP: begin
          for (int i = 0; i < MC; i++) begin
            mrk[i] <= placed[i];
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (fin_go) begin
            out_id    <= (kind == crc_pkg::KIND_ENCODE && !bad) ?
                         rem[crc_pkg::ID_W-1:0] : '0;
            out_blk   <= blk;
            out_mrk   <= mrk;
            out_bad   <= bad;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.id_out      = out_id;
  assign rsp.black_out_a = out_blk[0];
  assign rsp.black_out_b = out_blk[1];
  assign rsp.black_out_c = out_blk[2];
  assign rsp.mark_out_a  = out_mrk[0];
  assign rsp.mark_out_b  = out_mrk[1];
  assign rsp.mark_out_c  = out_mrk[2];
  assign rsp.mark_out_d  = out_mrk[3];
  assign rsp.bad_input   = out_bad;

  a_bad_id_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_bad) |-> (out_id == '0))
    else $error("flagged item carries a nonzero id");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_EADD && kind == crc_pkg::KIND_DECODE) |=> (rem < CALC_W'(MARKSPAN)))
    else $error("division remainder not below the mark span");

  a_id_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && kind == crc_pkg::KIND_ENCODE && !bad) |-> (rem < CALC_W'(TOTAL)))
    else $error("encoded id out of range");

  a_black_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_bad && UB > 1) |-> (out_blk[0] < out_blk[1]))
    else $error("black positions not ascending");

endmodule
